/* rtl/core/fawr_pkg.sv */
// shared types and constants for the fraction alu
`default_nettype none
package fawr_pkg;
   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_DIV = 2'd3;
   localparam int WORK_W = 34;
   localparam int OUT_W = 32;
   localparam int DIV_STEPS = 34;
   localparam logic signed [WORK_W-1:0] MAG_LIMIT = 34'sd2147483647;

   typedef struct packed {
      logic load;
      logic red_step;
      logic div_start;
      logic div_step;
      logic finish;
   } fawr_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic red_done;
      logic need_split;
      logic div_last;
   } fawr_sts_type;
endpackage
`default_nettype wire

/* rtl/core/fraction_alu_with_reduction_top.sv */
// top level of the fraction alu with prime reduction
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | func a_negative a_num a_den b_num b_den
//  rsp     | out | rsp_valid/rsp_stall  | whole_part res_num res_den negative div_error
// one item at a time: a zero denominator goes straight to the result beat, else
// the operands are loaded, then reduced by one step per prime test or exact
// divide, then split by the restoring divider when a whole part is split
// synchronous reset returns the controller to idle; the result beat holds
// under rsp_stall and req_stall is high until it is taken
`default_nettype none
module fraction_alu_with_reduction_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic               req_a_negative,
   input  wire logic signed [15:0] req_a_num,
   input  wire logic signed [15:0] req_a_den,
   input  wire logic signed [15:0] req_b_num,
   input  wire logic signed [15:0] req_b_den,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_whole_part,
   output logic signed [31:0]      rsp_res_num,
   output logic signed [31:0]      rsp_res_den,
   output logic                    rsp_negative,
   output logic                    rsp_div_error
);
   import fawr_pkg::*;
   fawr_cmd_type cmd;
   fawr_sts_type sts;
   logic err;
   logic signed [31:0] w, rn, rd;
   logic ng;

   fawr_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .err_sel(err), .cmd, .sts
   );
   fawr_datapath u_dp (
      .clock, .cmd, .sts, .req_func, .req_a_negative, .req_a_num,
      .req_a_den, .req_b_num, .req_b_den,
      .whole_part(w), .res_num(rn), .res_den(rd), .negative(ng)
   );

   assign rsp_whole_part = err ? 32'sd0 : w;
   assign rsp_res_num = err ? 32'sd0 : rn;
   assign rsp_res_den = err ? 32'sd0 : rd;
   assign rsp_negative = err ? 1'b0 : ng;
   assign rsp_div_error = err;
endmodule
`default_nettype wire

/* rtl/core/fawr_datapath.sv */
// datapath: operand products, prime reduction and whole part division
`default_nettype none
module fawr_datapath (
   input  wire logic                  clock,
   input  wire fawr_pkg::fawr_cmd_type cmd,
   output fawr_pkg::fawr_sts_type     sts,
   input  wire logic [1:0]            req_func,
   input  wire logic                  req_a_negative,
   input  wire logic signed [15:0]    req_a_num,
   input  wire logic signed [15:0]    req_a_den,
   input  wire logic signed [15:0]    req_b_num,
   input  wire logic signed [15:0]    req_b_den,
   output logic signed [31:0]         whole_part,
   output logic signed [31:0]         res_num,
   output logic signed [31:0]         res_den,
   output logic                       negative
);
   import fawr_pkg::*;

   // inverses of the odd factors 9, 7, 5 and 3 mod 2^32 and the largest exact quotients
   localparam logic [31:0] INV_9 = 32'h38E38E39;
   localparam logic [31:0] INV_7 = 32'hB6DB6DB7;
   localparam logic [31:0] INV_5 = 32'hCCCCCCCD;
   localparam logic [31:0] INV_3 = 32'hAAAAAAAB;
   localparam logic [31:0] LIM_9 = 32'h1C71C71C;
   localparam logic [31:0] LIM_7 = 32'h24924924;
   localparam logic [31:0] LIM_5 = 32'h33333333;
   localparam logic [31:0] LIM_3 = 32'h55555555;

   // raw terms from cross products, up to about 2^31 plus sign
   logic signed [WORK_W-1:0] n_ff, n_in, d_ff, d_in;
   logic [2:0] pidx_ff, pidx_in;
   logic [WORK_W-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0] cnt_ff, cnt_in;
   logic qneg_ff, qneg_in, rneg_ff, rneg_in;

   logic signed [16:0] an, ad, bn, bd;
   logic signed [WORK_W-1:0] p1, p2, p3, rawn, rawd;

   always_comb begin
      an = req_a_negative ? -{req_a_num[15], req_a_num} : {req_a_num[15], req_a_num};
      ad = {req_a_den[15], req_a_den};
      bn = {req_b_num[15], req_b_num};
      bd = {req_b_den[15], req_b_den};
      p1 = WORK_W'(an * bd);
      p2 = WORK_W'(bn * ad);
      p3 = WORK_W'(ad * bd);
      unique case (req_func)
         FUNC_ADD: begin
            rawn = (ad != bd) ? p1 + p2 : WORK_W'(an + bn);
            rawd = (ad != bd) ? p3 : WORK_W'(ad);
         end
         FUNC_SUB: begin
            rawn = (ad != bd) ? p1 - p2 : WORK_W'(an - bn);
            rawd = (ad != bd) ? p3 : WORK_W'(ad);
         end
         FUNC_MUL: begin
            rawn = WORK_W'(an * bn);
            rawd = p3;
         end
         default: begin
            rawn = p1;
            rawd = WORK_W'(ad * bn);
         end
      endcase
   end

   logic [WORK_W-1:0] nabs, dabs;
   logic [WORK_W:0] trial;
   assign nabs = n_ff[WORK_W-1] ? WORK_W'(-n_ff) : WORK_W'(n_ff);
   assign dabs = d_ff[WORK_W-1] ? WORK_W'(-d_ff) : WORK_W'(d_ff);
   assign trial = {rem_ff, quo_ff[WORK_W-1]} - {1'b0, dvs_ff};

   // one divisibility test per cycle against the current factor
   // magnitudes stay within 32 bits; an odd factor divides exactly when the
   // product with its inverse stays at or below the quotient limit
   logic [31:0] inv, lim, nprod, dprod, nqm, dqm;
   logic signed [WORK_W-1:0] nq, dq;
   logic nok, dok;
   always_comb begin
      unique case (pidx_ff)
         3'd0: begin inv = INV_9; lim = LIM_9; end
         3'd1: begin inv = INV_7; lim = LIM_7; end
         3'd2: begin inv = INV_5; lim = LIM_5; end
         3'd3: begin inv = INV_3; lim = LIM_3; end
         default: begin inv = 32'd1; lim = '1; end
      endcase
      nprod = nabs[31:0] * inv;
      dprod = dabs[31:0] * inv;
      if (pidx_ff >= 3'd4) begin
         nok = !nabs[0];
         dok = !dabs[0];
         nqm = {1'b0, nabs[31:1]};
         dqm = {1'b0, dabs[31:1]};
      end else begin
         nok = (nprod <= lim);
         dok = (dprod <= lim);
         nqm = nprod;
         dqm = dprod;
      end
      nq = WORK_W'(nqm);
      dq = WORK_W'(dqm);
      if (n_ff[WORK_W-1]) nq = -nq;
      if (d_ff[WORK_W-1]) dq = -dq;
   end

   always_comb begin
      n_in = n_ff; d_in = d_ff; pidx_in = pidx_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff;
      if (cmd.load) begin
         n_in = rawn; d_in = rawd; pidx_in = 3'd0;
      end else if (cmd.red_step) begin
         if (nok && dok) begin
            n_in = nq; d_in = dq;
         end else begin
            pidx_in = pidx_ff + 3'd1;
         end
      end else if (cmd.div_start) begin
         rem_in = '0; quo_in = nabs; dvs_in = dabs; cnt_in = '0;
         qneg_in = n_ff[WORK_W-1] ^ d_ff[WORK_W-1];
         rneg_in = n_ff[WORK_W-1];
      end else if (cmd.div_step) begin
         if (!trial[WORK_W]) begin
            rem_in = trial[WORK_W-1:0];
            quo_in = {quo_ff[WORK_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORK_W-2:0], quo_ff[WORK_W-1]};
            quo_in = {quo_ff[WORK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; d_ff <= d_in; pidx_ff <= pidx_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   assign sts.den_zero = (rawd == '0);
   assign sts.red_done = (pidx_ff == 3'd4) && !(nok && dok);
   assign sts.need_split = d_ff < n_ff;
   assign sts.div_last = (cnt_ff == 6'(DIV_STEPS));

   function automatic logic signed [31:0] sat(input logic signed [WORK_W-1:0] v);
      if (v > MAG_LIMIT) return 32'sd2147483647;
      if (v < -MAG_LIMIT) return -32'sd2147483647;
      return v[31:0];
   endfunction

   logic signed [WORK_W-1:0] wq, wr;
   assign wq = qneg_ff ? WORK_W'(-quo_ff) : WORK_W'(quo_ff);
   assign wr = rneg_ff ? WORK_W'(-rem_ff) : WORK_W'(rem_ff);

   logic signed [31:0] w_ff, rn_ff, rd_ff;
   logic ng_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         w_ff <= sts.need_split ? sat(wq) : 32'sd0;
         rn_ff <= sts.need_split ? sat(wr) : sat(n_ff);
         rd_ff <= sat(d_ff);
         ng_ff <= n_ff[WORK_W-1] | d_ff[WORK_W-1];
      end
   end
   assign whole_part = w_ff;
   assign res_num = rn_ff;
   assign res_den = rd_ff;
   assign negative = ng_ff;
endmodule
`default_nettype wire

/* rtl/core/fawr_control.sv */
// controller: sequences load, reduction, division and result beat
`default_nettype none
module fawr_control (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        err_sel,
   output fawr_pkg::fawr_cmd_type      cmd,
   input  wire fawr_pkg::fawr_sts_type sts
);
   import fawr_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_DIV = 3'd2,
                          S_FIN = 3'd3, S_OUT = 3'd4;
   logic [2:0] state_ff, state_in;
   logic err_ff, err_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign err_sel = err_ff;

   always_comb begin
      state_in = state_ff; err_in = err_ff; cmd = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            err_in = sts.den_zero;
            state_in = sts.den_zero ? S_OUT : S_RED;
         end
         S_RED: begin
            cmd.red_step = 1'b1;
            if (sts.red_done) begin
               if (sts.need_split) state_in = S_DIV;
               else state_in = S_FIN;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (sts.need_split && !sts.div_last) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // finish comes in the cycle after the last divide step
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff <= err_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/fawr_checker.sv */
// port checker for the fraction alu, bound to the top level
`default_nettype none
module fawr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_whole_part,
   input wire logic [31:0] rsp_res_num,
   input wire logic        rsp_div_error
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_num))
      else $error("result beat dropped under stall");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_error |-> rsp_whole_part == 0 && rsp_res_num == 0)
      else $error("error beat carries data");
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted item did not occupy block");
endmodule

bind fraction_alu_with_reduction_top fawr_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_whole_part, .rsp_res_num, .rsp_div_error
);
`default_nettype wire

/* sim/fraction_alu_with_reduction_top_test.sv */
// testbench for the fraction alu: directed and random fraction operations checked against a predictor
`default_nettype none
module fraction_alu_with_reduction_top_test;
   import fawr_pkg::*;

   typedef struct {
      logic signed [31:0] whole;
      logic signed [31:0] num;
      logic signed [31:0] den;
      logic               neg;
      logic               err;
   } fraction_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_func = FUNC_ADD;
   logic req_a_negative = 1'b0;
   logic signed [15:0] req_a_num = '0;
   logic signed [15:0] req_a_den = 16'sd1;
   logic signed [15:0] req_b_num = '0;
   logic signed [15:0] req_b_den = 16'sd1;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_whole_part;
   logic signed [31:0] rsp_res_num;
   logic signed [31:0] rsp_res_den;
   logic rsp_negative;
   logic rsp_div_error;

   fraction_result_type expected_results[$];
   int error_count = 0;
   int result_count = 0;
   int sent_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   fraction_alu_with_reduction_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_a_negative(req_a_negative),
      .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_whole_part(rsp_whole_part), .rsp_res_num(rsp_res_num),
      .rsp_res_den(rsp_res_den), .rsp_negative(rsp_negative),
      .rsp_div_error(rsp_div_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200000000;
      $display("fraction_alu_with_reduction_top_test: FAIL");
      $finish;
   end

   function automatic longint clamp_mag(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
   endfunction

   function automatic fraction_result_type compute_fraction(logic [1:0] op, logic neg_a,
         logic signed [15:0] an16, logic signed [15:0] ad16,
         logic signed [15:0] bn16, logic signed [15:0] bd16);
      fraction_result_type r;
      longint an, ad, bn, bd, n, d, whole;
      int primes[5];
      an = an16; ad = ad16; bn = bn16; bd = bd16;
      primes = '{9, 7, 5, 3, 2};
      whole = 0;
      if (neg_a) an = -an;
      case (op)
         FUNC_ADD: begin
            if (ad != bd) begin n = an * bd + bn * ad; d = ad * bd; end
            else begin n = an + bn; d = ad; end
         end
         FUNC_SUB: begin
            if (ad != bd) begin n = an * bd - bn * ad; d = ad * bd; end
            else begin n = an - bn; d = ad; end
         end
         FUNC_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      r = '{0, 0, 0, 1'b0, 1'b0};
      if (d == 0) begin
         r.err = 1'b1;
         return r;
      end
      foreach (primes[i])
         while ((n % primes[i] == 0) && (d % primes[i] == 0)) begin
            n = n / primes[i];
            d = d / primes[i];
         end
      r.neg = (d < 0) || (n < 0);
      if (d < n) begin
         whole = n / d;
         n = n % d;
      end
      r.whole = 32'(clamp_mag(whole));
      r.num = 32'(clamp_mag(n));
      r.den = 32'(clamp_mag(d));
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on result %0d: %s got %0d expected %0d",
               result_count, field, got, want);
      error_count++;
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_whole_part !== want.whole)
               report_mismatch("whole_part", rsp_whole_part, want.whole);
            if (rsp_res_num !== want.num) report_mismatch("res_num", rsp_res_num, want.num);
            if (rsp_res_den !== want.den) report_mismatch("res_den", rsp_res_den, want.den);
            if (rsp_negative !== want.neg) report_mismatch("negative", rsp_negative, want.neg);
            if (rsp_div_error !== want.err)
               report_mismatch("div_error", rsp_div_error, want.err);
         end
         result_count++;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // called at a falling edge; returns at the falling edge after the beat is
   // taken with valid still high, so the next call or a drain takes it over
   task automatic send_fraction(logic [1:0] op, logic neg_a, logic signed [15:0] an,
         logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= op;
      req_a_negative <= neg_a;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(compute_fraction(op, neg_a, an, ad, bn, bd));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [1:0] op;
      for (int k = 0; k < 4; k++) begin
         op = k[1:0];
         send_fraction(op, 1'b0, 16'sd1, 16'sd3, 16'sd1, 16'sd3);
         send_fraction(op, 1'b1, 16'sd32767, 16'sd2, -16'sd32767, 16'sd5);
         send_fraction(op, 1'b0, 16'sd5, 16'sd0, 16'sd1, 16'sd2);
      end
      // divide by a zero numerator gives an error
      send_fraction(FUNC_DIV, 1'b0, 16'sd3, 16'sd4, 16'sd0, 16'sd7);
      // zero numerator still reduces the denominator
      send_fraction(FUNC_MUL, 1'b0, 16'sd0, 16'sd6, 16'sd5, 16'sd3);
      // negative denominator splits a whole part
      send_fraction(FUNC_MUL, 1'b0, 16'sd5, -16'sd3, 16'sd1, 16'sd1);
      send_fraction(FUNC_MUL, 1'b0, 16'sd441, 16'sd63, 16'sd1, 16'sd1);
      send_fraction(FUNC_ADD, 1'b0, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767);
      send_fraction(FUNC_MUL, 1'b1, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1);
      send_fraction(FUNC_SUB, 1'b0, 16'sd32767, 16'sd1, -16'sd32767, -16'sd1);
      send_fraction(FUNC_DIV, 1'b1, -16'sd32767, -16'sd1, 16'sd1, 16'sd32767);
      drain_results();
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(3))
         0: return 16'($urandom_range(20) - 10);
         1: return 16'($urandom_range(2000) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_random(int count);
      logic signed [15:0] ad, bd;
      for (int k = 0; k < count; k++) begin
         ad = pick_value();
         bd = ($urandom_range(3) == 0) ? ad : pick_value();
         send_fraction(2'($urandom_range(3)), 1'($urandom_range(1)), pick_value(), ad,
                       pick_value(), bd);
         // hold off once until everything has come back
         if (k == count / 2) drain_results();
      end
      drain_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 12; recv_idle_pct = 82;
      test_random(450);
      send_idle_pct = 82; recv_idle_pct = 12;
      test_random(450);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(450);
      $display("sent %0d fraction requests over all operations, %0d results checked",
               sent_count, result_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("fraction_alu_with_reduction_top_test: PASS");
      end else begin
         $display("fraction_alu_with_reduction_top_test: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
